// ===== hw/rtl/jdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_pkg
// Shared types, widths and codes for the joystick direction debouncer.
// ----------------------------------------------------------------------------
package jdd_pkg;

  // Converter sample width and timestamp width.
  localparam int ADC_BITS  = 10;
  localparam int TIME_BITS = 32;

  // Register widths.
  localparam int DELAY_W   = 16;
  localparam int THR_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Signed deflection: one bit for the sign, one for the subtraction range.
  localparam int DEFL_W = ADC_BITS + 2;

  // Width of the value a debouncer tracks (a direction code or a button bit).
  localparam int DBN_W = 3;

  // Register reset values.
  localparam int DELAY_RESET  = 50;
  localparam int OFFSET_RESET = 512;
  localparam int THR_RESET    = 255;

  typedef enum logic [DBN_W-1:0] {
    DIR_CENTER = 3'd0,
    DIR_RIGHT  = 3'd1,
    DIR_LEFT   = 3'd2,
    DIR_UP     = 3'd3,
    DIR_DOWN   = 3'd4
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS = 2'd0,
    REG_X_OFFSET    = 2'd1,
    REG_Y_OFFSET    = 2'd2,
    REG_THRESHOLD   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DELAY_W-1:0]  debounce_ms;
    logic [ADC_BITS-1:0] x_offset;
    logic [ADC_BITS-1:0] y_offset;
    logic [THR_W-1:0]    deflect_thr;
  } cfg_t;

endpackage

// ===== hw/rtl/jdd_poll_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_poll_if
// Poll channel: two axis samples, the raw button level and a timestamp.
// ----------------------------------------------------------------------------
interface jdd_poll_if;
  logic                          valid;
  logic                          ready;
  logic [jdd_pkg::ADC_BITS-1:0]  x_sample;
  logic [jdd_pkg::ADC_BITS-1:0]  y_sample;
  logic                          button_level;
  logic [jdd_pkg::TIME_BITS-1:0] now_ms;

  modport source (output valid, x_sample, y_sample, button_level, now_ms, input ready);
  modport sink (input valid, x_sample, y_sample, button_level, now_ms, output ready);
endinterface

// ===== hw/rtl/jdd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_result_if
// Result channel: debounced direction and button state with edge flags.
// ----------------------------------------------------------------------------
interface jdd_result_if;
  logic                       valid;
  logic                       ready;
  logic [jdd_pkg::DBN_W-1:0]  direction;
  logic [jdd_pkg::DBN_W-1:0]  prev_direction;
  logic                       pressed;
  logic                       press_edge;
  logic                       release_edge;

  modport source (output valid, direction, prev_direction, pressed, press_edge,
                  release_edge, input ready);
  modport sink (input valid, direction, prev_direction, pressed, press_edge,
                release_edge, output ready);
endinterface

// ===== hw/rtl/jdd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface jdd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [jdd_pkg::CFG_IDX_W-1:0] index;
  logic [jdd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/jdd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module jdd_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  jdd_cfg_if.sink         cfg,
  output jdd_pkg::cfg_t   regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms <= jdd_pkg::DELAY_W'(jdd_pkg::DELAY_RESET);
      regs.x_offset    <= jdd_pkg::ADC_BITS'(jdd_pkg::OFFSET_RESET);
      regs.y_offset    <= jdd_pkg::ADC_BITS'(jdd_pkg::OFFSET_RESET);
      regs.deflect_thr <= jdd_pkg::THR_W'(jdd_pkg::THR_RESET);
    end else if (cfg.valid) begin
      case (jdd_pkg::cfg_idx_t'(cfg.index))
        jdd_pkg::REG_DEBOUNCE_MS: regs.debounce_ms <= cfg.data[jdd_pkg::DELAY_W-1:0];
        jdd_pkg::REG_X_OFFSET:    regs.x_offset <= cfg.data[jdd_pkg::ADC_BITS-1:0];
        jdd_pkg::REG_Y_OFFSET:    regs.y_offset <= cfg.data[jdd_pkg::ADC_BITS-1:0];
        jdd_pkg::REG_THRESHOLD:   regs.deflect_thr <= cfg.data[jdd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/jdd_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_classify
// Turns two raw axis samples into a raw direction code.
// ----------------------------------------------------------------------------
module jdd_classify (
  input  logic [jdd_pkg::ADC_BITS-1:0] x_sample,
  input  logic [jdd_pkg::ADC_BITS-1:0] y_sample,
  input  jdd_pkg::cfg_t                regs,
  output jdd_pkg::dir_t                raw_dir
);

  logic signed [jdd_pkg::DEFL_W-1:0] x_defl;
  logic signed [jdd_pkg::DEFL_W-1:0] y_defl;
  logic signed [jdd_pkg::DEFL_W-1:0] thr_pos;
  logic signed [jdd_pkg::DEFL_W-1:0] thr_neg;
  logic x_pos, x_neg, y_pos, y_neg;

  assign x_defl  = $signed(jdd_pkg::DEFL_W'(x_sample)) - $signed(jdd_pkg::DEFL_W'(regs.x_offset));
  assign y_defl  = $signed(jdd_pkg::DEFL_W'(y_sample)) - $signed(jdd_pkg::DEFL_W'(regs.y_offset));
  assign thr_pos = $signed(jdd_pkg::DEFL_W'(regs.deflect_thr));
  assign thr_neg = -thr_pos;

  // The positive test wins, so a zero threshold counts zero deflection as positive.
  assign x_pos = (x_defl >= thr_pos);
  assign x_neg = (x_defl <= thr_neg);
  assign y_pos = (y_defl >= thr_pos);
  assign y_neg = (y_defl <= thr_neg);

  // A decided Y axis overrides X.
  always_comb begin
    if (y_pos) begin
      raw_dir = jdd_pkg::DIR_UP;
    end else if (y_neg) begin
      raw_dir = jdd_pkg::DIR_DOWN;
    end else if (x_pos) begin
      raw_dir = jdd_pkg::DIR_RIGHT;
    end else if (x_neg) begin
      raw_dir = jdd_pkg::DIR_LEFT;
    end else begin
      raw_dir = jdd_pkg::DIR_CENTER;
    end
  end

endmodule

// ===== hw/rtl/jdd_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdd_debounce
// One debouncer: candidate, change time, stable and previous values.
// ----------------------------------------------------------------------------
module jdd_debounce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [jdd_pkg::DBN_W-1:0]     raw,
  input  logic [jdd_pkg::TIME_BITS-1:0] now_ms,
  input  logic [jdd_pkg::DELAY_W-1:0]   delay,
  output logic [jdd_pkg::DBN_W-1:0]     stable_next,
  output logic [jdd_pkg::DBN_W-1:0]     previous_next
);

  logic [jdd_pkg::DBN_W-1:0]     candidate;
  logic [jdd_pkg::DBN_W-1:0]     stable;
  logic [jdd_pkg::DBN_W-1:0]     previous;
  logic [jdd_pkg::TIME_BITS-1:0] change_time;
  logic [jdd_pkg::TIME_BITS-1:0] age;
  logic                          changed;
  logic                          settled;

  assign changed = (raw != candidate);
  assign age     = now_ms - change_time;
  // A change restarts the timer, so a changed sample is never taken as settled.
  assign settled = !changed && (age > jdd_pkg::TIME_BITS'(delay));

  assign stable_next   = settled ? raw : stable;
  assign previous_next = settled ? stable : previous;

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate   <= '0;
      stable      <= '0;
      previous    <= '0;
      change_time <= '0;
    end else if (step) begin
      candidate <= raw;
      stable    <= stable_next;
      previous  <= previous_next;
      if (changed) begin
        change_time <= now_ms;
      end
    end
  end

endmodule

// ===== hw/rtl/joystick_direction_debouncer.sv =====
`timescale 1ns / 1ps
// Path: a poll transferred on the poll channel is held in the poll register and then
// in the result register, from which its result transfers on the result channel.
// Throughput: one poll per cycle while the result channel keeps ready high.
// Reset (synchronous, rst high): configuration returns to its reset values,
// both debouncers return to center and released, and both channels empty.
// ----------------------------------------------------------------------------
// joystick_direction_debouncer
// Classifies joystick polls into a direction and debounces direction and button.
// ----------------------------------------------------------------------------
module joystick_direction_debouncer (
  input  logic          clk,
  input  logic          rst,
  jdd_poll_if.sink      poll,
  jdd_result_if.source  result,
  jdd_cfg_if.sink       cfg
);

  // The design is two registers deep. The poll register captures each
  // transfer on the poll channel. Between it and the result register sit the
  // axis classifier and the two debouncers; the debouncer state moves forward
  // at the same edge that loads the result register, so the next poll sees
  // the state that the one before it left and may follow in the next cycle.

  jdd_pkg::cfg_t regs;

  logic                          s1_valid;
  logic [jdd_pkg::ADC_BITS-1:0]  s1_x;
  logic [jdd_pkg::ADC_BITS-1:0]  s1_y;
  logic                          s1_button;
  logic [jdd_pkg::TIME_BITS-1:0] s1_now;

  logic advance;
  logic load_s1;
  logic step;

  jdd_pkg::dir_t             raw_dir;
  logic [jdd_pkg::DBN_W-1:0] raw_btn;
  logic [jdd_pkg::DBN_W-1:0] dir_stable_next;
  logic [jdd_pkg::DBN_W-1:0] dir_previous_next;
  logic [jdd_pkg::DBN_W-1:0] btn_stable_next;
  logic [jdd_pkg::DBN_W-1:0] btn_previous_next;

  logic                      res_valid;
  logic [jdd_pkg::DBN_W-1:0] res_direction;
  logic [jdd_pkg::DBN_W-1:0] res_prev_direction;
  logic                      res_pressed;
  logic                      res_press_edge;
  logic                      res_release_edge;

  jdd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The result register can take a new item when it is empty or being drained.
  // An empty poll register still takes a poll while the result register waits,
  // so the poll channel is held off only when both registers are full and the
  // result is not being taken.
  assign advance    = !res_valid || result.ready;
  assign poll.ready = !s1_valid || advance;
  assign load_s1    = poll.valid && poll.ready;
  assign step       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load_s1) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_x      <= poll.x_sample;
      s1_y      <= poll.y_sample;
      s1_button <= poll.button_level;
      s1_now    <= poll.now_ms;
    end
  end

  jdd_classify u_classify (
    .x_sample (s1_x),
    .y_sample (s1_y),
    .regs     (regs),
    .raw_dir  (raw_dir)
  );

  jdd_debounce u_dir_debounce (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .raw           (raw_dir),
    .now_ms        (s1_now),
    .delay         (regs.debounce_ms),
    .stable_next   (dir_stable_next),
    .previous_next (dir_previous_next)
  );

  // The pin is active low; the button debouncer tracks only bit 0.
  assign raw_btn = jdd_pkg::DBN_W'(!s1_button);

  jdd_debounce u_btn_debounce (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .raw           (raw_btn),
    .now_ms        (s1_now),
    .delay         (regs.debounce_ms),
    .stable_next   (btn_stable_next),
    .previous_next (btn_previous_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_direction      <= dir_stable_next;
      res_prev_direction <= dir_previous_next;
      res_pressed        <= btn_stable_next[0];
      res_press_edge     <= !btn_previous_next[0] && btn_stable_next[0];
      res_release_edge   <= btn_previous_next[0] && !btn_stable_next[0];
    end
  end

  assign result.valid          = res_valid;
  assign result.direction      = res_direction;
  assign result.prev_direction = res_prev_direction;
  assign result.pressed        = res_pressed;
  assign result.press_edge     = res_press_edge;
  assign result.release_edge   = res_release_edge;

`ifndef SYNTHESIS
  // A poll in the poll register that meets a free result register comes out next cycle.
  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result.valid)
    else $error("poll moved on but no result appeared");

  // A press edge always comes with the debounced button pressed.
  a_press_edge_pressed: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.press_edge) |-> result.pressed)
    else $error("press edge without pressed button");

  // A release edge always comes with the debounced button released.
  a_release_edge_released: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.release_edge) |-> !result.pressed)
    else $error("release edge with pressed button");

  // The poll channel is only held off while a poll is waiting in the poll register.
  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !poll.ready |-> (s1_valid && res_valid && !result.ready))
    else $error("poll channel held off without a waiting poll");
`endif

endmodule
